// ===== src/wsfp_pkg.sv =====
package wsfp_pkg;

  // Parser phases.
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LEN16   = 3'd1;
  localparam logic [2:0] PH_LEN64   = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Result event codes.
  localparam logic [2:0] EV_HDR_BYTE  = 3'd0;
  localparam logic [2:0] EV_HDR_DONE  = 3'd1;
  localparam logic [2:0] EV_PAYLOAD   = 3'd2;
  localparam logic [2:0] EV_FRAG_CTRL = 3'd3;
  localparam logic [2:0] EV_BAD_OPC   = 3'd4;
  localparam logic [2:0] EV_TOO_LONG  = 3'd5;

  // Seven-bit length codes that select an extended length field.
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Extended length field sizes, modulo eight as the byte counter wraps.
  localparam logic [2:0] LEN16_BYTES = 3'd2;
  localparam logic [2:0] LEN64_BYTES = 3'd0;

  // Opcode classes.
  localparam logic [3:0] OPC_DATA_LAST = 4'd2;
  localparam logic [3:0] OPC_CTRL_FIRST = 4'd8;
  localparam logic [3:0] OPC_CTRL_LAST  = 4'd10;

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_MAX_PAYLOAD_LENGTH = 1'b0;
  localparam logic [31:0] MAX_PAYLOAD_LENGTH_RESET = 32'hFFFF_FFFF;

  localparam int unsigned WSFP_QUEUE_DEPTH = 4;

  // One classified byte, as handed from the front to the back.
  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  raw_byte;
    logic [7:0]  key_byte;
    logic        masked;
    logic [3:0]  opcode;
    logic        fin;
    logic [31:0] length;
    logic        frame_end;
  } wsfp_item_t;

endpackage

// ===== src/wsfp_if.sv =====
interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface wsfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  out_byte;
  logic [3:0]  opcode;
  logic        fin_flag;
  logic        masked_flag;
  logic [31:0] payload_length;
  logic        frame_end;

  modport source(output valid, output event_res, output out_byte, output opcode,
                 output fin_flag, output masked_flag, output payload_length,
                 output frame_end, input ready);
  modport sink(input valid, input event_res, input out_byte, input opcode,
               input fin_flag, input masked_flag, input payload_length,
               input frame_end, output ready);
endinterface

// ===== src/wsfp_front.sv =====
module wsfp_front
  import wsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wsfp_in_if.sink     in_ch,
  input  logic [31:0] max_payload_length,
  input  logic        q_ready,
  output logic        q_push,
  output wsfp_item_t  q_item
);

  logic [2:0]  phase, phase_next;
  logic [2:0]  fcount, fcount_next;
  logic [31:0] acc_lo, acc_lo_next;
  logic        acc_hi_nz, acc_hi_nz_next;
  logic [3:0]  opc, opc_next;
  logic        fin, fin_next;
  logic        masked, masked_next;
  logic [31:0] key, key_next;
  logic [31:0] remaining, remaining_next;
  logic [1:0]  kidx, kidx_next;

  logic [7:0]  b;
  logic [2:0]  ev;
  logic        fend;
  logic        do_after;
  logic [7:0]  key_byte;
  logic        is_ctrl;
  logic        is_data;
  logic        accept;

  assign b        = in_ch.data_byte;
  assign accept   = in_ch.valid && q_ready;
  assign in_ch.ready = q_ready;
  assign is_ctrl  = (opc >= OPC_CTRL_FIRST) && (opc <= OPC_CTRL_LAST);
  assign is_data  = (opc <= OPC_DATA_LAST);
  assign key_byte = key[{kidx, 3'b000} +: 8];

  always_comb begin
    phase_next     = phase;
    fcount_next    = fcount;
    acc_lo_next    = acc_lo;
    acc_hi_nz_next = acc_hi_nz;
    opc_next       = opc;
    fin_next       = fin;
    masked_next    = masked;
    key_next       = key;
    remaining_next = remaining;
    kidx_next      = kidx;
    ev             = EV_HDR_BYTE;
    fend           = 1'b0;
    do_after       = 1'b0;

    case (phase)
      PH_LEN16, PH_LEN64: begin
        acc_lo_next    = {acc_lo[23:0], b};
        acc_hi_nz_next = acc_hi_nz || (acc_lo[31:24] != 8'd0);
        fcount_next    = fcount + 3'd1;
        if (fcount_next == ((phase == PH_LEN16) ? LEN16_BYTES : LEN64_BYTES)) begin
          if ((phase == PH_LEN64) &&
              (acc_hi_nz_next || (acc_lo_next > max_payload_length))) begin
            ev          = EV_TOO_LONG;
            phase_next  = PH_HEADER;
            fcount_next = 3'd0;
          end else begin
            do_after = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_next[{fcount[1:0], 3'b000} +: 8] = key[{fcount[1:0], 3'b000} +: 8] | b;
        fcount_next = fcount + 3'd1;
        if (fcount_next[2]) begin
          fcount_next    = 3'd0;
          ev             = EV_HDR_DONE;
          remaining_next = acc_lo;
          kidx_next      = 2'd0;
          if (acc_lo != 32'd0) begin
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next = PH_HEADER;
            fend       = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        ev             = EV_PAYLOAD;
        kidx_next      = kidx + 2'd1;
        remaining_next = remaining - 32'd1;
        if (remaining_next == 32'd0) begin
          fend       = 1'b1;
          phase_next = PH_HEADER;
        end
      end
      default: begin
        if (fcount == 3'd0) begin
          phase_next     = PH_HEADER;
          fin_next       = b[7];
          opc_next       = b[3:0];
          masked_next    = 1'b0;
          acc_lo_next    = 32'd0;
          acc_hi_nz_next = 1'b0;
          key_next       = 32'd0;
          kidx_next      = 2'd0;
          remaining_next = 32'd0;
          fcount_next    = 3'd1;
        end else begin
          masked_next = b[7];
          fcount_next = 3'd0;
          if (!is_ctrl && !is_data) begin
            ev = EV_BAD_OPC;
          end else if (is_ctrl && !fin) begin
            ev = EV_FRAG_CTRL;
          end else if (b[6:0] == LEN_CODE_16) begin
            phase_next = PH_LEN16;
          end else if (b[6:0] == LEN_CODE_64) begin
            phase_next = PH_LEN64;
          end else begin
            acc_lo_next = {25'd0, b[6:0]};
            do_after    = 1'b1;
          end
        end
      end
    endcase

    // Length is known: go to the mask key, the payload or the next header.
    if (do_after) begin
      fcount_next = 3'd0;
      if (masked_next) begin
        phase_next = PH_KEY;
        ev         = EV_HDR_BYTE;
      end else begin
        ev             = EV_HDR_DONE;
        remaining_next = acc_lo_next;
        kidx_next      = 2'd0;
        if (acc_lo_next != 32'd0) begin
          phase_next = PH_PAYLOAD;
        end else begin
          phase_next = PH_HEADER;
          fend       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      fcount    <= 3'd0;
      acc_lo    <= 32'd0;
      acc_hi_nz <= 1'b0;
      opc       <= 4'd0;
      fin       <= 1'b0;
      masked    <= 1'b0;
      key       <= 32'd0;
      remaining <= 32'd0;
      kidx      <= 2'd0;
    end else if (accept) begin
      phase     <= phase_next;
      fcount    <= fcount_next;
      acc_lo    <= acc_lo_next;
      acc_hi_nz <= acc_hi_nz_next;
      opc       <= opc_next;
      fin       <= fin_next;
      masked    <= masked_next;
      key       <= key_next;
      remaining <= remaining_next;
      kidx      <= kidx_next;
    end
  end

  assign q_push           = accept;
  assign q_item.ev        = ev;
  assign q_item.raw_byte  = b;
  assign q_item.key_byte  = key_byte;
  assign q_item.masked    = masked_next;
  assign q_item.opcode    = opc_next;
  assign q_item.fin       = fin_next;
  assign q_item.length    = acc_lo_next;
  assign q_item.frame_end = fend;

endmodule

// ===== src/wsfp_queue.sv =====
module wsfp_queue
  import wsfp_pkg::*;
#(
  parameter int unsigned DEPTH = WSFP_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  wsfp_item_t push_item,
  output logic       push_ready,
  input  logic       pop,
  output logic       pop_valid,
  output wsfp_item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  wsfp_item_t       mem [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == LAST_PTR) ? '0 : tail + PTR_W'(1);
      end
      if (do_pop) begin
        head <= (head == LAST_PTR) ? '0 : head + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/wsfp_back.sv =====
module wsfp_back
  import wsfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  wsfp_item_t q_item,
  output logic       q_pop,
  wsfp_out_if.source out_ch
);

  logic       out_valid;
  logic       load;
  logic [7:0] unmasked;

  assign load  = q_valid && (!out_valid || out_ch.ready);
  assign q_pop = load;

  always_comb begin
    unmasked = 8'd0;
    if (q_item.ev == EV_PAYLOAD) begin
      unmasked = q_item.masked ? (q_item.raw_byte ^ q_item.key_byte) : q_item.raw_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.event_res      <= q_item.ev;
      out_ch.out_byte       <= unmasked;
      out_ch.opcode         <= q_item.opcode;
      out_ch.fin_flag       <= q_item.fin;
      out_ch.masked_flag    <= q_item.masked;
      out_ch.payload_length <= q_item.length;
      out_ch.frame_end      <= q_item.frame_end;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== src/websocket_frame_parser.sv =====
// Channel   Direction  Payload                                   Transfer
// in_ch     in         data_byte                                 valid & ready
// out_ch    out        event_res, out_byte, opcode, fin_flag,    valid & ready
//                      masked_flag, payload_length, frame_end
// APB       in/out     max_payload_length at byte address 0      psel & penable & pwrite
//
// One byte is taken per cycle while the queue has room, and gives one result.
// A result is written into the queue when its byte transfers, and is then
// loaded into the output register of the back, from which it transfers out.
// The front parser state is updated in the cycle a byte transfers, so that
// state loop sets the rate of one byte per cycle.
// Reset is synchronous and returns the parser to header parsing.
// A stalled output fills the queue; the input stalls only once it is full.
module websocket_frame_parser
  import wsfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = WSFP_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  wsfp_in_if.sink            in_ch,
  wsfp_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration register. Writes must happen only while the parser is idle;
  // the block does not enforce this. The front reads the register directly.
  logic [31:0] max_payload_length;
  logic        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_MAX_PAYLOAD_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= MAX_PAYLOAD_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_payload_length <= pwdata;
    end
  end

  // Reads of addresses beyond the register return zero.
  assign prdata = reg_hit ? max_payload_length : 32'd0;

  // The front classifies each byte and pushes a finished result record
  // into the queue; the back unmasks payload bytes and holds the output.
  logic       q_push;
  logic       q_ready;
  wsfp_item_t q_in_item;
  logic       q_pop;
  logic       q_valid;
  wsfp_item_t q_out_item;

  wsfp_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_ch              (in_ch),
    .max_payload_length (max_payload_length),
    .q_ready            (q_ready),
    .q_push             (q_push),
    .q_item             (q_in_item)
  );

  wsfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out_item)
  );

  wsfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_out_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
